// ----- hdl/rde_pkg.sv -----
// shared types and constants for the ring deque engine
`default_nettype none

package rde_pkg;

   // field widths of the channels
   localparam int FUNC_W     = 3;
   localparam int VAL_W      = 32;
   localparam int POS_W      = 8;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 8;
   localparam int CAP_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int WIDE_W     = 64;

   typedef logic [FUNC_W-1:0]     func_type;
   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;

   // operation codes
   localparam func_type FUNC_PUSH_BACK  = 3'd0;
   localparam func_type FUNC_PUSH_FRONT = 3'd1;
   localparam func_type FUNC_POP_FRONT  = 3'd2;
   localparam func_type FUNC_POP_BACK   = 3'd3;
   localparam func_type FUNC_GET        = 3'd4;
   localparam func_type FUNC_CLEAR      = 3'd5;

   // status codes
   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;
   localparam status_type STATUS_RANGE = 2'd3;

   // register indexes
   localparam csr_idx_type CSR_CAPACITY  = 2'd0;
   localparam csr_idx_type CSR_OVERWRITE = 2'd1;

   localparam logic [CAP_W-1:0] CAP_RESET = 8'd255;

   // result fields that travel beside the memory read
   typedef struct packed {
      status_type         status;
      logic               has_read;
      logic [COUNT_W-1:0] element_count;
      logic               is_empty;
      logic               is_full;
      logic               dropped;
   } rsp_info_type;

endpackage

`default_nettype wire

// ----- hdl/rde_ifs.sv -----
// channel interfaces of the ring deque engine
`default_nettype none

interface rde_req_if import rde_pkg::*;;
   logic                 valid;
   logic                 ready;
   func_type             func;
   logic [VAL_W-1:0]     push_value;
   logic [POS_W-1:0]     position;

   modport source (output valid, func, push_value, position, input ready);
   modport sink   (input valid, func, push_value, position, output ready);
endinterface

interface rde_rsp_if import rde_pkg::*;;
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [VAL_W-1:0]     read_value;
   logic [COUNT_W-1:0]   element_count;
   logic                 is_empty;
   logic                 is_full;
   logic                 dropped;

   modport source (output valid, status, read_value, element_count, is_empty, is_full,
                   dropped, input ready);
   modport sink   (input valid, status, read_value, element_count, is_empty, is_full,
                   dropped, output ready);
endinterface

interface rde_csr_if import rde_pkg::*;;
   logic                    valid;
   logic                    ready;
   csr_idx_type             index;
   logic [CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/rde_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module rde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ring_deque_engine.sv -----
// ring deque engine: double-ended ring queue over a slot ram
//
// Channels: req_port carries one operation per item (func, push_value, position);
// rsp_port returns exactly one result item per request (status, read_value,
// element_count, is_empty, is_full, dropped). csr_port writes capacity_in_use
// (index 0, also empties the queue) and overwrite_on_full (index 1); it is
// always ready; users must write it only while the block is idle (it has no guard).
// Timing: a result passes through the pending stage, which takes the slot ram's
// registered read, and then the output register before it is valid. Throughput:
// one item per cycle while the receiver takes results; each item does its pointer
// update and at most one ram access in the cycle it is accepted.
// A one-entry stage holds the ram read data and result fields, and the output
// register parts it from the receiver: when rsp_port stalls, the engine still
// takes one more item, then holds req_port.ready low until the output drains.
// Reset: pointers go to zero, capacity_in_use to 255, overwrite_on_full to 0 and
// no result is pending. Slot contents are not cleared; a slot is only read
// after it has been written.
`default_nettype none

module ring_deque_engine import rde_pkg::*; #(
   parameter int SLOTS     = 256,
   parameter int ELEM_BITS = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   rde_req_if.sink    req_port,
   rde_rsp_if.source  rsp_port,
   rde_csr_if.sink    csr_port
);

   localparam int PTR_W = $clog2(SLOTS);
   localparam int AW    = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
   localparam logic [AW-1:0] LAST_MAX = AW'(SLOTS - 1);

   // configuration and pointer state
   logic [CAP_W-1:0]     cap_ff;
   logic                 ovw_ff;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;

   // pending stage and output register
   logic                 pend_valid_ff, pend_valid_in;
   rsp_info_type         pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_info_type         rsp_ff;
   logic [VAL_W-1:0]     rsp_value_ff, rsp_value_in;

   logic                 pend_move;
   logic                 accept;
   logic                 csr_cap_write;

   // ring geometry
   logic [AW-1:0]        cap_ext;
   logic [AW-1:0]        last_w;
   logic [PTR_W-1:0]     last;
   logic [PTR_W:0]       wrap_fill;
   logic [PTR_W-1:0]     fill;
   logic                 full;
   logic [PTR_W-1:0]     inc_head, dec_head, inc_tail, dec_tail;
   logic [AW-1:0]        get_sum, get_wrap;
   logic [PTR_W-1:0]     get_addr;
   logic                 pos_bad;

   // memory access
   logic                 mem_wr, mem_rd;
   logic [PTR_W-1:0]     mem_addr;
   logic [ELEM_BITS-1:0] mem_wdata, mem_rdata;
   logic [WIDE_W-1:0]    wr_wide, rd_wide;
   logic [PTR_W-1:0]     count_after;

   // handshakes
   assign pend_move      = pend_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !pend_valid_ff || pend_move;
   assign accept         = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;
   assign csr_cap_write  = csr_port.valid && (csr_port.index == CSR_CAPACITY);

   // effective last slot index from the capacity register
   assign cap_ext = AW'(cap_ff);
   always_comb begin
      if (cap_ext == '0) begin
         last_w = AW'(1);
      end else if (cap_ext > LAST_MAX) begin
         last_w = LAST_MAX;
      end else begin
         last_w = cap_ext;
      end
   end
   assign last = last_w[PTR_W-1:0];

   // element count and pointer neighbors
   assign wrap_fill = (PTR_W+1)'(last) + (PTR_W+1)'(1) - (PTR_W+1)'(head_ff)
                      + (PTR_W+1)'(tail_ff);
   assign fill      = (tail_ff >= head_ff) ? (tail_ff - head_ff) : wrap_fill[PTR_W-1:0];
   assign full      = (fill == last);
   assign inc_head  = (head_ff == last) ? '0 : head_ff + PTR_W'(1);
   assign dec_head  = (head_ff == '0) ? last : head_ff - PTR_W'(1);
   assign inc_tail  = (tail_ff == last) ? '0 : tail_ff + PTR_W'(1);
   assign dec_tail  = (tail_ff == '0) ? last : tail_ff - PTR_W'(1);

   // indexed get address, head plus position modulo the ring size
   assign get_sum  = AW'(head_ff) + AW'(req_port.position);
   assign get_wrap = get_sum - (AW'(last) + AW'(1));
   assign get_addr = (get_sum > AW'(last)) ? get_wrap[PTR_W-1:0] : get_sum[PTR_W-1:0];
   assign pos_bad  = AW'(req_port.position) >= AW'(fill);

   // element width adaption
   assign wr_wide   = WIDE_W'(req_port.push_value);
   assign mem_wdata = wr_wide[ELEM_BITS-1:0];
   assign rd_wide   = WIDE_W'(mem_rdata);

   // operation decode: pointer update, at most one ram access, result fields
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      mem_wr      = 1'b0;
      mem_rd      = 1'b0;
      mem_addr    = tail_ff;
      count_after = fill;
      pend_in     = '0;
      if (accept) begin
         unique case (req_port.func)
            FUNC_PUSH_BACK: begin
               if (full && !ovw_ff) begin
                  pend_in.status = STATUS_FULL;
               end else begin
                  if (full) begin
                     head_in         = inc_head;
                     pend_in.dropped = 1'b1;
                  end else begin
                     count_after = fill + PTR_W'(1);
                  end
                  mem_wr   = 1'b1;
                  mem_addr = tail_ff;
                  tail_in  = inc_tail;
               end
            end
            FUNC_PUSH_FRONT: begin
               if (full && !ovw_ff) begin
                  pend_in.status = STATUS_FULL;
               end else begin
                  if (full) begin
                     tail_in         = dec_tail;
                     pend_in.dropped = 1'b1;
                  end else begin
                     count_after = fill + PTR_W'(1);
                  end
                  mem_wr   = 1'b1;
                  mem_addr = dec_head;
                  head_in  = dec_head;
               end
            end
            FUNC_POP_FRONT: begin
               if (fill == '0) begin
                  pend_in.status = STATUS_EMPTY;
               end else begin
                  mem_rd           = 1'b1;
                  mem_addr         = head_ff;
                  pend_in.has_read = 1'b1;
                  count_after      = fill - PTR_W'(1);
                  if (fill == PTR_W'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end else begin
                     head_in = inc_head;
                  end
               end
            end
            FUNC_POP_BACK: begin
               if (fill == '0) begin
                  pend_in.status = STATUS_EMPTY;
               end else begin
                  mem_rd           = 1'b1;
                  mem_addr         = dec_tail;
                  pend_in.has_read = 1'b1;
                  count_after      = fill - PTR_W'(1);
                  if (fill == PTR_W'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end else begin
                     tail_in = dec_tail;
                  end
               end
            end
            FUNC_GET: begin
               if (pos_bad) begin
                  pend_in.status = STATUS_RANGE;
               end else begin
                  mem_rd           = 1'b1;
                  mem_addr         = get_addr;
                  pend_in.has_read = 1'b1;
               end
            end
            FUNC_CLEAR: begin
               head_in     = '0;
               tail_in     = '0;
               count_after = '0;
            end
            default: begin
            end
         endcase
      end
      pend_in.element_count = COUNT_W'(count_after);
      pend_in.is_empty      = (count_after == '0);
      pend_in.is_full       = (count_after == last);
   end

   // slot storage
   rde_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (mem_addr),
      .wr_data (mem_wdata),
      .rd_en   (mem_rd),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

   // configuration and pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_RESET;
         ovw_ff  <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         if (csr_cap_write) begin
            cap_ff  <= csr_port.data[CAP_W-1:0];
            head_ff <= '0;
            tail_ff <= '0;
         end else begin
            head_ff <= head_in;
            tail_ff <= tail_in;
         end
         if (csr_port.valid && (csr_port.index == CSR_OVERWRITE)) begin
            ovw_ff <= csr_port.data[0];
         end
      end
   end

   // pending stage and output register control
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (accept) begin
         pend_valid_in = 1'b1;
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (pend_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_value_in = pend_ff.has_read ? rd_wide[VAL_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      if (pend_move) begin
         rsp_ff       <= pend_ff;
         rsp_value_ff <= rsp_value_in;
      end
   end

   // result channel
   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.status        = rsp_ff.status;
   assign rsp_port.read_value    = rsp_value_ff;
   assign rsp_port.element_count = rsp_ff.element_count;
   assign rsp_port.is_empty      = rsp_ff.is_empty;
   assign rsp_port.is_full       = rsp_ff.is_full;
   assign rsp_port.dropped       = rsp_ff.dropped;

endmodule

`default_nettype wire

// ----- verif/tb_ring_deque_engine.sv -----
// testbench for the ring deque engine: random and directed deque operations, checked in order
`timescale 1ns / 100ps

module tb_ring_deque_engine;
   import rde_pkg::*;

   // operation and register codes the package leaves unnamed
   localparam func_type    FUNC_NOP_A  = 3'd6;
   localparam func_type    FUNC_NOP_B  = 3'd7;
   localparam csr_idx_type CSR_SPARE_A = 2'd2;
   localparam csr_idx_type CSR_SPARE_B = 2'd3;

   typedef struct packed {
      status_type         status;
      logic [VAL_W-1:0]   read_value;
      logic [COUNT_W-1:0] element_count;
      logic               is_empty;
      logic               is_full;
      logic               dropped;
   } deque_outcome_type;

   // deque mirror plus the queue of outcomes still owed by the block
   class deque_scoreboard;
      logic [VAL_W-1:0]  slots [256];
      int                head;
      int                tail;
      logic [CAP_W-1:0]  cap_reg;
      logic              wrap_mode;
      deque_outcome_type awaited [$];
      int                errors;

      function new();
         head = 0;
         tail = 0;
         cap_reg = CAP_RESET;
         wrap_mode = 1'b0;
         errors = 0;
         foreach (slots[i]) slots[i] = '0;
      endfunction

      // ring length is the usable capacity plus the spare slot
      function int ring_slots();
         return ((cap_reg == 0) ? 1 : int'(cap_reg)) + 1;
      endfunction

      function int fill();
         if (tail >= head) return tail - head;
         return ring_slots() - head + tail;
      endfunction

      function int back_one(int p);
         return (p == 0) ? ring_slots() - 1 : p - 1;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void set_register(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CAPACITY: begin
               cap_reg = data;
               head = 0;
               tail = 0;
            end
            CSR_OVERWRITE: wrap_mode = data[0];
            default: ;
         endcase
      endfunction

      // apply one accepted operation and queue the outcome it should produce
      function void note_op(func_type f, logic [VAL_W-1:0] v, logic [POS_W-1:0] p);
         int                r;
         int                n;
         bit                full;
         deque_outcome_type o;
         r = ring_slots();
         n = fill();
         full = (n == r - 1);
         o = '0;
         o.status = STATUS_OK;
         case (f)
            FUNC_PUSH_BACK: begin
               if (full && !wrap_mode) begin
                  o.status = STATUS_FULL;
               end else begin
                  if (full) begin
                     head = (head + 1) % r;
                     o.dropped = 1'b1;
                  end
                  slots[tail] = v;
                  tail = (tail + 1) % r;
               end
            end
            FUNC_PUSH_FRONT: begin
               if (full && !wrap_mode) begin
                  o.status = STATUS_FULL;
               end else begin
                  if (full) begin
                     tail = back_one(tail);
                     o.dropped = 1'b1;
                  end
                  head = back_one(head);
                  slots[head] = v;
               end
            end
            FUNC_POP_FRONT: begin
               if (n == 0) begin
                  o.status = STATUS_EMPTY;
               end else begin
                  o.read_value = slots[head];
                  head = (head + 1) % r;
                  if (head == tail) begin
                     head = 0;
                     tail = 0;
                  end
               end
            end
            FUNC_POP_BACK: begin
               if (n == 0) begin
                  o.status = STATUS_EMPTY;
               end else begin
                  tail = back_one(tail);
                  o.read_value = slots[tail];
                  if (head == tail) begin
                     head = 0;
                     tail = 0;
                  end
               end
            end
            FUNC_GET: begin
               if (int'(p) >= n) o.status = STATUS_RANGE;
               else o.read_value = slots[(head + int'(p)) % r];
            end
            FUNC_CLEAR: begin
               head = 0;
               tail = 0;
            end
            default: ;
         endcase
         n = fill();
         o.element_count = n[COUNT_W-1:0];
         o.is_empty = (n == 0);
         o.is_full = (n == r - 1);
         awaited.push_back(o);
      endfunction

      function void diff_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
         end
      endfunction

      // compare a result item with the oldest outcome owed
      function void check_result(deque_outcome_type got);
         deque_outcome_type want;
         if (awaited.size() == 0) begin
            $error("result item with no operation outstanding");
            errors++;
            return;
         end
         want = awaited.pop_front();
         diff_field("status", VAL_W'(want.status), VAL_W'(got.status));
         diff_field("read_value", want.read_value, got.read_value);
         diff_field("element_count", VAL_W'(want.element_count), VAL_W'(got.element_count));
         diff_field("is_empty", VAL_W'(want.is_empty), VAL_W'(got.is_empty));
         diff_field("is_full", VAL_W'(want.is_full), VAL_W'(got.is_full));
         diff_field("dropped", VAL_W'(want.dropped), VAL_W'(got.dropped));
      endfunction
   endclass

   logic clock;
   logic reset;

   rde_req_if req_if ();
   rde_rsp_if rsp_if ();
   rde_csr_if csr_if ();

   deque_scoreboard sb = new();
   int              calm_left = 0;

   ring_deque_engine dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   // clock
   always #5 clock = ~clock;

   // known values on every input from time zero
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.func = FUNC_PUSH_BACK;
      req_if.push_value = '0;
      req_if.position = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_CAPACITY;
      csr_if.data = '0;
   end

   // mostly no gap, some short ones, a few long
   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 60) return 0;
      if (k < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // send one operation item and wait until it is taken
   task automatic put_op(func_type f, logic [VAL_W-1:0] v, logic [POS_W-1:0] p);
      int gap;
      if (calm_left > 0) begin
         gap = 0;
         calm_left--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 60);
      end
      repeat (gap) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.func = f;
      req_if.push_value = v;
      req_if.position = p;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_op(f, v, p);
   endtask

   // register write once the block has drained
   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_if.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data = data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // random operation, push_pct steers the fill level up or down
   task automatic random_op(int push_pct);
      int               pick;
      int               cnt;
      int               k;
      func_type         f;
      logic [VAL_W-1:0] v;
      logic [POS_W-1:0] p;
      pick = $urandom_range(0, 99);
      cnt = sb.fill();
      k = $urandom_range(0, 9);
      v = (k == 0) ? '0 : (k == 1) ? '1 : VAL_W'($urandom);
      p = ($urandom_range(0, 4) != 0) ? POS_W'($urandom_range(0, cnt))
                                      : POS_W'($urandom_range(0, 255));
      if (pick < 10) f = FUNC_GET;
      else if (pick == 10 && push_pct <= 50) f = FUNC_CLEAR;
      else if (pick == 11) f = $urandom_range(0, 1) ? FUNC_NOP_A : FUNC_NOP_B;
      else if ($urandom_range(0, 99) < push_pct)
         f = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
      else
         f = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
      put_op(f, v, p);
   endtask

   // result side ready: runs of acceptance broken by stalls
   initial begin : rsp_stall
      int run;
      int pause;
      forever begin
         run = ($urandom_range(0, 9) < 2) ? $urandom_range(20, 80) : $urandom_range(1, 6);
         repeat (run) begin
            @(negedge clock);
            rsp_if.ready = 1'b1;
         end
         pause = pick_gap();
         repeat (pause) begin
            @(negedge clock);
            rsp_if.ready = 1'b0;
         end
      end
   end

   // check each result item taken
   always @(posedge clock) begin
      deque_outcome_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.status = rsp_if.status;
         got.read_value = rsp_if.read_value;
         got.element_count = rsp_if.element_count;
         got.is_empty = rsp_if.is_empty;
         got.is_full = rsp_if.is_full;
         got.dropped = rsp_if.dropped;
         sb.check_result(got);
      end
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // main sequence
   initial begin : stimulus
      int               bias;
      logic [CAP_W-1:0] cap;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty queue errors, value extremes, gets in and out of range, unused codes
      put_op(FUNC_POP_FRONT, '0, '0);
      put_op(FUNC_POP_BACK, '0, '0);
      put_op(FUNC_GET, '0, '0);
      put_op(FUNC_PUSH_BACK, '1, '0);
      put_op(FUNC_PUSH_FRONT, '0, '1);
      put_op(FUNC_PUSH_BACK, 32'hA5A5_5A5A, '0);
      put_op(FUNC_GET, '0, 8'd0);
      put_op(FUNC_GET, '0, 8'd2);
      put_op(FUNC_GET, '0, 8'd3);
      put_op(FUNC_GET, '0, '1);
      put_op(FUNC_NOP_A, 32'h1234_5678, '0);
      put_op(FUNC_NOP_B, 32'h8765_4321, '0);
      put_op(FUNC_POP_BACK, '0, '0);
      put_op(FUNC_POP_FRONT, '0, '0);
      put_op(FUNC_CLEAR, '0, '0);
      put_op(FUNC_POP_FRONT, '0, '0);

      // single element ring: rejected pushes, then overwrite with contents kept
      write_reg(CSR_CAPACITY, 8'd1);
      write_reg(CSR_OVERWRITE, 8'd0);
      put_op(FUNC_PUSH_BACK, 32'hCAFE_0001, '0);
      put_op(FUNC_PUSH_BACK, 32'hCAFE_0002, '0);
      put_op(FUNC_PUSH_FRONT, 32'hCAFE_0003, '0);
      write_reg(CSR_OVERWRITE, 8'hFF);
      put_op(FUNC_PUSH_BACK, 32'hCAFE_0004, '0);
      put_op(FUNC_PUSH_FRONT, 32'hCAFE_0005, '0);
      put_op(FUNC_GET, '0, '0);
      put_op(FUNC_POP_BACK, '0, '0);

      // random phases over several capacity and overwrite settings
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 0) cap = 8'd0;
         else if (ph == 1) cap = 8'd255;
         else if ($urandom_range(0, 3) == 0) cap = CAP_W'($urandom_range(13, 255));
         else cap = CAP_W'($urandom_range(1, 12));
         write_reg(CSR_CAPACITY, cap);
         write_reg(CSR_OVERWRITE, CSR_DATA_W'($urandom_range(0, 255)));
         if (ph % 4 == 3)
            write_reg((ph % 8 == 3) ? CSR_SPARE_A : CSR_SPARE_B, CSR_DATA_W'($urandom));
         if (ph == 1) begin
            // push-heavy operations on the largest ring, then pop-heavy ones
            repeat (300) random_op(88);
            repeat (40) random_op(10);
         end else begin
            for (int seg = 0; seg < 5; seg++) begin
               case ($urandom_range(0, 2))
                  0: bias = 80;
                  1: bias = 20;
                  default: bias = 50;
               endcase
               repeat (20) random_op(bias);
            end
         end
      end

      // drain and finish
      @(negedge clock);
      req_if.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
